// ----- design/cxa_pkg.sv -----
package cxa_pkg;

    // Default build parameters
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH      = 4;

    // Internal datapath widths
    localparam int RW       = 96;   // divider / square-root remainder
    localparam int CW       = 40;   // CORDIC x and y
    localparam int ZW       = 32;   // CORDIC angle
    localparam int UW       = 36;   // angle reduction remainder
    localparam int B_STAGES = 32;   // digit stages of divide and square root

    // Angle constants in Q30 and CORDIC gain
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    // Operation codes
    typedef logic [3:0] mode_t;
    localparam mode_t MODE_ADD = 4'd0;
    localparam mode_t MODE_SUB = 4'd1;
    localparam mode_t MODE_MUL = 4'd2;
    localparam mode_t MODE_DIV = 4'd3;
    localparam mode_t MODE_CNJ = 4'd4;
    localparam mode_t MODE_NEG = 4'd5;
    localparam mode_t MODE_MAG = 4'd6;
    localparam mode_t MODE_ARG = 4'd7;
    localparam mode_t MODE_POL = 4'd8;
    localparam mode_t MODE_EQU = 4'd9;

    // Execution class picked by the front end
    typedef enum logic [2:0] {
        CLS_SIMPLE,
        CLS_MUL,
        CLS_DIV,
        CLS_MAG,
        CLS_ATAN,
        CLS_POLAR
    } cls_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               equal_flag;
        logic               error_flag;
    } rsp_t;

    typedef struct packed {
        cls_t               cls;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        rsp_t               sres;
    } queue_t;

    typedef struct packed {
        logic               err;
        logic signed [31:0] val;
    } sat_t;

    // Saturate a signed value to 32 bits
    function automatic sat_t sat32(input logic signed [71:0] v);
        sat_t r;
        if (v > 72'sd2147483647) begin
            r.err = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            r.err = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.err = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    // Saturate a sign and magnitude pair to 32 bits
    function automatic sat_t sat_sm(input logic neg, input logic [63:0] mag);
        sat_t        r;
        logic [63:0] n;
        n = 64'd0 - mag;
        r.err = 1'b0;
        if (neg) begin
            if (mag > 64'h80000000) begin
                r.err = 1'b1;
                r.val = 32'sh80000000;
            end else begin
                r.val = n[31:0];
            end
        end else begin
            if (mag > 64'h7FFFFFFF) begin
                r.err = 1'b1;
                r.val = 32'sh7FFFFFFF;
            end else begin
                r.val = mag[31:0];
            end
        end
        return r;
    endfunction

    // Q30 angle rounded half up to the working format
    function automatic longint q30_to_q(input longint t, input int s);
        return (t + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Arctangent of 2^-i in Q30
    function automatic longint atan_q30(input int i);
        case (i)
            0:       return 64'sd843314857;
            1:       return 64'sd497837829;
            2:       return 64'sd263043837;
            3:       return 64'sd133525159;
            4:       return 64'sd67021687;
            5:       return 64'sd33543516;
            6:       return 64'sd16775851;
            7:       return 64'sd8388437;
            8:       return 64'sd4194283;
            9:       return 64'sd2097149;
            10:      return 64'sd1048576;
            default: return (i <= 30) ? (longint'(1) << (30 - i)) : 64'sd0;
        endcase
    endfunction

endpackage

// ----- design/cxa_front.sv -----
module cxa_front
    import cxa_pkg::*;
(
    input  req_t   req,
    output queue_t entry
);

    logic signed [71:0] ar_x;
    logic signed [71:0] ai_x;
    logic signed [71:0] br_x;
    logic signed [71:0] bi_x;
    sat_t add_re, add_im, sub_re, sub_im, neg_re, neg_im;

    assign ar_x = 72'(req.a_re);
    assign ai_x = 72'(req.a_im);
    assign br_x = 72'(req.b_re);
    assign bi_x = 72'(req.b_im);

    // Short operations finish here
    assign add_re = sat32(ar_x + br_x);
    assign add_im = sat32(ai_x + bi_x);
    assign sub_re = sat32(ar_x - br_x);
    assign sub_im = sat32(ai_x - bi_x);
    assign neg_re = sat32(-ar_x);
    assign neg_im = sat32(-ai_x);

    // Classify and build the queue entry
    always_comb
    begin
        entry.a_re = req.a_re;
        entry.a_im = req.a_im;
        entry.b_re = req.b_re;
        entry.b_im = req.b_im;
        entry.cls  = CLS_SIMPLE;
        entry.sres = '0;
        unique case (req.mode)
            MODE_ADD:
            begin
                entry.sres.res_re     = add_re.val;
                entry.sres.res_im     = add_im.val;
                entry.sres.error_flag = add_re.err | add_im.err;
            end
            MODE_SUB:
            begin
                entry.sres.res_re     = sub_re.val;
                entry.sres.res_im     = sub_im.val;
                entry.sres.error_flag = sub_re.err | sub_im.err;
            end
            MODE_CNJ:
            begin
                entry.sres.res_re     = req.a_re;
                entry.sres.res_im     = neg_im.val;
                entry.sres.error_flag = neg_im.err;
            end
            MODE_NEG:
            begin
                entry.sres.res_re     = neg_re.val;
                entry.sres.res_im     = neg_im.val;
                entry.sres.error_flag = neg_re.err | neg_im.err;
            end
            MODE_EQU:
            begin
                entry.sres.equal_flag = (req.a_re == req.b_re) && (req.a_im == req.b_im);
            end
            MODE_MUL: entry.cls = CLS_MUL;
            MODE_DIV: entry.cls = CLS_DIV;
            MODE_MAG: entry.cls = CLS_MAG;
            MODE_ARG: entry.cls = CLS_ATAN;
            MODE_POL: entry.cls = CLS_POLAR;
            default:  entry.cls = CLS_SIMPLE;
        endcase
    end

endmodule

// ----- design/cxa_fifo.sv -----
module cxa_fifo
    import cxa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  queue_t din,
    input  logic   pop,
    output queue_t dout,
    output logic   full,
    output logic   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    queue_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]   count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// ----- design/cxa_back.sv -----
module cxa_back
    import cxa_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  queue_t q_data,
    output logic   q_pop,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output rsp_t   rsp
);

    localparam int ANG_SHIFT = 30 - FRAC_BITS;
    localparam int MODS      = 32 - FRAC_BITS;
    localparam int DM        = 2 + B_STAGES;
    localparam int DC        = MODS + CORDIC_STEPS + 2;
    localparam int D         = (DM > DC) ? DM : DC;
    localparam int PM        = D - DM;
    localparam int PC        = D - DC;

    localparam logic signed [ZW-1:0] HALF_Q = ZW'(q30_to_q(HALF_PI_Q30, ANG_SHIFT));
    localparam logic signed [UW:0]   PI_S   = (UW+1)'(q30_to_q(PI_Q30, ANG_SHIFT));
    localparam logic signed [UW:0]   TPI_S  = (UW+1)'(q30_to_q(TWO_PI_Q30, ANG_SHIFT));
    localparam logic signed [UW:0]   HPI_S  = (UW+1)'(q30_to_q(HALF_PI_Q30, ANG_SHIFT));
    localparam logic [UW-1:0]        TPI_U  = UW'(q30_to_q(TWO_PI_Q30, ANG_SHIFT));
    localparam logic signed [31:0]   GAIN_S = 32'(GAIN_Q30);

    typedef struct packed {
        logic [RW-1:0] r0;
        logic [RW-1:0] r1;
        logic [31:0]   q0;
        logic [31:0]   q1;
        logic          neg0;
        logic          neg1;
        logic          ovf0;
        logic          ovf1;
        logic          dz;
        logic          err;
        logic [63:0]   den;
    } mb_t;

    typedef struct packed {
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic               s;
        logic [UW-1:0]      u;
    } mod_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 rot;
        logic                 zero;
        logic                 flip;
    } cc_t;

    typedef struct packed {
        logic signed [71:0]   px;
        logic signed [71:0]   py;
        logic signed [ZW-1:0] z;
        logic                 zero;
        logic                 flip;
    } g_t;

    logic en;

    // Control line, one slot per pipeline stage
    logic vld_reg     [D+1];
    cls_t cls_line_reg[D+1];
    rsp_t sres_reg    [D+1];

    // Multiply / divide / square root track
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq0_reg, sq1_reg;
    logic signed [64:0] s0, s1;
    logic               neg0_reg, neg1_reg;
    logic [63:0]        mag0_reg, mag1_reg, den_reg;
    mb_t                b_init;
    mb_t                mb_in  [B_STAGES];
    mb_t                mb_nx  [B_STAGES];
    mb_t                mb_reg [B_STAGES];
    mb_t                mpad_reg [PM+1];
    sat_t               mul0, mul1;

    // CORDIC track
    mod_t mod_in  [MODS];
    mod_t mod_nx  [MODS];
    mod_t mod_reg [MODS];
    cc_t  pre_nx, pre_reg;
    cc_t  cc_in  [CORDIC_STEPS];
    cc_t  cc_nx  [CORDIC_STEPS];
    cc_t  cc_reg [CORDIC_STEPS];
    g_t   g_reg;
    g_t   cpad_reg [PC+1];
    logic [UW-1:0]    zp;
    logic signed [UW:0] zs, zr;

    // Result stage
    rsp_t               rsp_next, rsp_reg;
    logic               rsp_vld_reg;
    sat_t               div0, div1, magr, pol_re, pol_im;
    logic signed [71:0] xs, ys;
    logic [63:0]        qn0, qn1;

    assign en    = !rsp_vld_reg || rsp_ready;
    assign q_pop = en && q_valid;

    // Control line valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= D; i++)
                vld_reg[i] <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= q_valid;
            for (int i = 1; i <= D; i++)
                vld_reg[i] <= vld_reg[i-1];
            rsp_vld_reg <= vld_reg[D];
        end
    end

    // Control line payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_line_reg[0] <= q_data.cls;
            sres_reg[0]     <= q_data.sres;
            for (int i = 1; i <= D; i++)
            begin
                cls_line_reg[i] <= cls_line_reg[i-1];
                sres_reg[i]     <= sres_reg[i-1];
            end
        end
    end

    // Partial products; squares of A for magnitude, of B otherwise
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg <= 64'(q_data.a_re) * 64'(q_data.b_re);
            p_ii_reg <= 64'(q_data.a_im) * 64'(q_data.b_im);
            p_ri_reg <= 64'(q_data.a_re) * 64'(q_data.b_im);
            p_ir_reg <= 64'(q_data.a_im) * 64'(q_data.b_re);
            if (q_data.cls == CLS_MAG)
            begin
                sq0_reg <= 64'(q_data.a_re) * 64'(q_data.a_re);
                sq1_reg <= 64'(q_data.a_im) * 64'(q_data.a_im);
            end
            else
            begin
                sq0_reg <= 64'(q_data.b_re) * 64'(q_data.b_re);
                sq1_reg <= 64'(q_data.b_im) * 64'(q_data.b_im);
            end
        end
    end

    // Numerator sums and denominator
    always_comb
    begin
        if (cls_line_reg[0] == CLS_MUL)
        begin
            s0 = 65'(p_rr_reg) - 65'(p_ii_reg);
            s1 = 65'(p_ri_reg) + 65'(p_ir_reg);
        end
        else
        begin
            s0 = 65'(p_rr_reg) + 65'(p_ii_reg);
            s1 = 65'(p_ir_reg) - 65'(p_ri_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg <= s0[64];
            neg1_reg <= s1[64];
            mag0_reg <= s0[64] ? 64'(-s0) : s0[63:0];
            mag1_reg <= s1[64] ? 64'(-s1) : s1[63:0];
            den_reg  <= $unsigned(sq0_reg) + $unsigned(sq1_reg);
        end
    end

    // Product scaling and saturation
    assign mul0 = sat_sm(neg0_reg, mag0_reg >> FRAC_BITS);
    assign mul1 = sat_sm(neg1_reg, mag1_reg >> FRAC_BITS);

    // Seed of the digit stages
    always_comb
    begin
        b_init      = '0;
        b_init.neg0 = neg0_reg;
        b_init.neg1 = neg1_reg;
        b_init.den  = den_reg;
        b_init.dz   = (den_reg == 64'd0);
        case (cls_line_reg[1])
            CLS_DIV:
            begin
                b_init.r0 = RW'(mag0_reg) << FRAC_BITS;
                b_init.r1 = RW'(mag1_reg) << FRAC_BITS;
            end
            CLS_MAG:
            begin
                b_init.r0 = RW'(den_reg);
            end
            CLS_MUL:
            begin
                b_init.q0  = mul0.val;
                b_init.q1  = mul1.val;
                b_init.err = mul0.err | mul1.err;
            end
            default: ;
        endcase
    end

    assign mb_in[0] = b_init;

    // One quotient or root bit per stage
    for (genvar j = 0; j < B_STAGES; j++)
    begin : g_digit
        localparam int K = B_STAGES - 1 - j;
        logic [RW-1:0] td, tm;

        if (j > 0)
        begin : g_link
            assign mb_in[j] = mb_reg[j-1];
        end

        assign td = RW'(mb_in[j].den) << K;
        assign tm = (RW'(mb_in[j].q0) << (K + 1)) + (RW'(1) << (2 * K));

        always_comb
        begin
            mb_nx[j] = mb_in[j];
            case (cls_line_reg[1+j])
                CLS_DIV:
                begin
                    if (j == 0)
                    begin
                        mb_nx[j].ovf0 = (mb_in[j].r0 >= td);
                        mb_nx[j].ovf1 = (mb_in[j].r1 >= td);
                    end
                    else
                    begin
                        if (mb_in[j].r0 >= td)
                        begin
                            mb_nx[j].r0    = mb_in[j].r0 - td;
                            mb_nx[j].q0[K] = 1'b1;
                        end
                        if (mb_in[j].r1 >= td)
                        begin
                            mb_nx[j].r1    = mb_in[j].r1 - td;
                            mb_nx[j].q1[K] = 1'b1;
                        end
                    end
                end
                CLS_MAG:
                begin
                    if (mb_in[j].r0 >= tm)
                    begin
                        mb_nx[j].r0    = mb_in[j].r0 - tm;
                        mb_nx[j].q0[K] = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en)
                mb_reg[j] <= mb_nx[j];
        end
    end

    // Alignment delay for the digit track
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mpad_reg[0] <= mb_reg[B_STAGES-1];
            for (int i = 1; i <= PM; i++)
                mpad_reg[i] <= mpad_reg[i-1];
        end
    end

    // Angle reduction seed: magnitude and sign of the polar angle
    always_comb
    begin
        mod_in[0].ar = q_data.a_re;
        mod_in[0].ai = q_data.a_im;
        mod_in[0].s  = q_data.a_im[31];
        mod_in[0].u  = q_data.a_im[31] ? UW'(-33'(q_data.a_im)) : UW'(q_data.a_im);
    end

    // Remainder by two pi, one shifted subtract per stage
    for (genvar m = 0; m < MODS; m++)
    begin : g_mod
        localparam int K = MODS - 1 - m;
        logic [UW-1:0] t;

        if (m > 0)
        begin : g_link
            assign mod_in[m] = mod_reg[m-1];
        end

        assign t = TPI_U << K;

        always_comb
        begin
            mod_nx[m] = mod_in[m];
            if (mod_in[m].u >= t)
                mod_nx[m].u = mod_in[m].u - t;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                mod_reg[m] <= mod_nx[m];
        end
    end

    // Polar angle wrap into the range above minus pi up to pi
    always_comb
    begin
        zp = (mod_reg[MODS-1].s && mod_reg[MODS-1].u != '0) ?
             TPI_U - mod_reg[MODS-1].u : mod_reg[MODS-1].u;
        zs = $signed({1'b0, zp});
        if (zs > PI_S)
            zs = zs - TPI_S;
        zr = zs;
    end

    // CORDIC set-up
    always_comb
    begin
        pre_nx      = '0;
        pre_nx.zero = 1'b0;
        if (cls_line_reg[MODS-1] == CLS_POLAR)
        begin
            pre_nx.rot = 1'b1;
            pre_nx.x   = CW'(mod_reg[MODS-1].ar);
            pre_nx.y   = '0;
            if (zr > HPI_S)
            begin
                pre_nx.z    = ZW'(zr - PI_S);
                pre_nx.flip = 1'b1;
            end
            else if (zr < -HPI_S)
            begin
                pre_nx.z    = ZW'(zr + PI_S);
                pre_nx.flip = 1'b1;
            end
            else
            begin
                pre_nx.z = ZW'(zr);
            end
        end
        else
        begin
            pre_nx.rot  = 1'b0;
            pre_nx.zero = (mod_reg[MODS-1].ar == 0) && (mod_reg[MODS-1].ai == 0);
            if (mod_reg[MODS-1].ar < 0)
            begin
                if (mod_reg[MODS-1].ai >= 0)
                begin
                    pre_nx.x = CW'(mod_reg[MODS-1].ai);
                    pre_nx.y = -CW'(mod_reg[MODS-1].ar);
                    pre_nx.z = HALF_Q;
                end
                else
                begin
                    pre_nx.x = -CW'(mod_reg[MODS-1].ai);
                    pre_nx.y = CW'(mod_reg[MODS-1].ar);
                    pre_nx.z = -HALF_Q;
                end
            end
            else
            begin
                pre_nx.x = CW'(mod_reg[MODS-1].ar);
                pre_nx.y = CW'(mod_reg[MODS-1].ai);
                pre_nx.z = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pre_reg <= pre_nx;
    end

    assign cc_in[0] = pre_reg;

    // CORDIC micro-rotations; rotation steers by z, vectoring by y
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] A_I = ZW'(q30_to_q(atan_q30(i), ANG_SHIFT));
        logic signed [CW-1:0] dx, dy;
        logic                 up;

        if (i > 0)
        begin : g_link
            assign cc_in[i] = cc_reg[i-1];
        end

        assign dx = cc_in[i].y >>> i;
        assign dy = cc_in[i].x >>> i;
        assign up = cc_in[i].rot ? (cc_in[i].z >= 0) : !(cc_in[i].y > 0);

        always_comb
        begin
            cc_nx[i] = cc_in[i];
            if (up)
            begin
                cc_nx[i].x = cc_in[i].x - dx;
                cc_nx[i].y = cc_in[i].y + dy;
                cc_nx[i].z = cc_in[i].z - A_I;
            end
            else
            begin
                cc_nx[i].x = cc_in[i].x + dx;
                cc_nx[i].y = cc_in[i].y - dy;
                cc_nx[i].z = cc_in[i].z + A_I;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                cc_reg[i] <= cc_nx[i];
        end
    end

    // Gain correction, rounding offset added
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg.px   <= 72'(cc_reg[CORDIC_STEPS-1].x) * 72'(GAIN_S) + 72'sd536870912;
            g_reg.py   <= 72'(cc_reg[CORDIC_STEPS-1].y) * 72'(GAIN_S) + 72'sd536870912;
            g_reg.z    <= cc_reg[CORDIC_STEPS-1].z;
            g_reg.zero <= cc_reg[CORDIC_STEPS-1].zero;
            g_reg.flip <= cc_reg[CORDIC_STEPS-1].flip;
        end
    end

    // Alignment delay for the CORDIC track
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpad_reg[0] <= g_reg;
            for (int i = 1; i <= PC; i++)
                cpad_reg[i] <= cpad_reg[i-1];
        end
    end

    // Final formatting of each track
    assign qn0    = 64'd0 - 64'(mpad_reg[PM].q0);
    assign qn1    = 64'd0 - 64'(mpad_reg[PM].q1);
    assign div0.err = mpad_reg[PM].ovf0;
    assign div0.val = mpad_reg[PM].ovf0 ?
                      (mpad_reg[PM].neg0 ? 32'sh80000000 : 32'sh7FFFFFFF) :
                      (mpad_reg[PM].neg0 ? qn0[31:0] : mpad_reg[PM].q0);
    assign div1.err = mpad_reg[PM].ovf1;
    assign div1.val = mpad_reg[PM].ovf1 ?
                      (mpad_reg[PM].neg1 ? 32'sh80000000 : 32'sh7FFFFFFF) :
                      (mpad_reg[PM].neg1 ? qn1[31:0] : mpad_reg[PM].q1);
    assign magr   = sat_sm(1'b0, 64'(mpad_reg[PM].q0));
    assign xs     = cpad_reg[PC].flip ? -(cpad_reg[PC].px >>> 30) : (cpad_reg[PC].px >>> 30);
    assign ys     = cpad_reg[PC].flip ? -(cpad_reg[PC].py >>> 30) : (cpad_reg[PC].py >>> 30);
    assign pol_re = sat32(xs);
    assign pol_im = sat32(ys);

    // Result select
    always_comb
    begin
        rsp_next = '0;
        case (cls_line_reg[D])
            CLS_SIMPLE: rsp_next = sres_reg[D];
            CLS_MUL:
            begin
                rsp_next.res_re     = mpad_reg[PM].q0;
                rsp_next.res_im     = mpad_reg[PM].q1;
                rsp_next.error_flag = mpad_reg[PM].err;
            end
            CLS_DIV:
            begin
                if (mpad_reg[PM].dz)
                begin
                    rsp_next.error_flag = 1'b1;
                end
                else
                begin
                    rsp_next.res_re     = div0.val;
                    rsp_next.res_im     = div1.val;
                    rsp_next.error_flag = div0.err | div1.err;
                end
            end
            CLS_MAG:
            begin
                rsp_next.res_re     = magr.val;
                rsp_next.error_flag = magr.err;
            end
            CLS_ATAN:
            begin
                rsp_next.res_re = cpad_reg[PC].zero ? 32'sd0 : 32'(cpad_reg[PC].z);
            end
            CLS_POLAR:
            begin
                rsp_next.res_re     = pol_re.val;
                rsp_next.res_im     = pol_im.val;
                rsp_next.error_flag = pol_re.err | pol_im.err;
            end
            default: rsp_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- design/complex_fixed_point_alu_top.sv -----
// Complex fixed-point ALU, signed Q16.16 operands by default.
// Request channel (req_valid/req_ready/req): mode plus operands A and B.
// Response channel (rsp_valid/rsp_ready/rsp): complex result, equality
// flag and error flag (division by zero or any saturation).
// A transfer happens on a rising edge with valid and ready both high.
// Throughput: one transfer per cycle on each side, all modes mixed,
// while rsp_ready stays high. The back end is a pipeline of depth D,
// where D = max(34, 34 - FRAC_BITS + CORDIC_STEPS).
// D is set by the 32 one-bit stages of the divider / square root and by
// the angle reduction plus CORDIC stages, whichever track is longer.
// The front end classifies each request and finishes add, subtract,
// conjugate, negate and compare; a small queue then feeds the back end.
// With rsp_ready low and a response waiting, the back end holds; the
// queue fills to 4 entries, then req_ready drops. Nothing is lost or
// repeated. Reset (rst_n low, asynchronous) empties the queue and the
// pipeline; the block takes requests on the first cycle after reset.
module complex_fixed_point_alu_top
    import cxa_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    queue_t entry, head;
    logic   q_full, q_empty, q_pop;

    assign req_ready = !q_full;

    cxa_front u_front (
        .req   (req),
        .entry (entry)
    );

    cxa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (req_valid && !q_full),
        .din   (entry),
        .pop   (q_pop),
        .dout  (head),
        .full  (q_full),
        .empty (q_empty)
    );

    cxa_back #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_empty),
        .q_data    (head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- verif/complex_fixed_point_alu_checker.sv -----
module complex_fixed_point_alu_checker
    import cxa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending_count
);
    localparam int FB = FRAC_BITS_DEF;
    localparam int NSTEP = CORDIC_STEPS_DEF;
    localparam int ASH = 30 - FB;

    rsp_t expected_rsp_q[$];
    int   reported;

    assign pending_count = expected_rsp_q.size();

    // floor division by 2^s on signed values
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint angle_fix(longint t);
        return (t + (longint'(1) << (ASH - 1))) >>> ASH;
    endfunction

    function automatic longint angle_step(int i);
        longint t;
        case (i)
            0: t = 843314857;
            1: t = 497837829;
            2: t = 263043837;
            3: t = 133525159;
            4: t = 67021687;
            5: t = 33543516;
            6: t = 16775851;
            7: t = 8388437;
            8: t = 4194283;
            9: t = 2097149;
            10: t = 1048576;
            default: t = (i <= 30) ? (longint'(1) << (30 - i)) : 0;
        endcase
        return angle_fix(t);
    endfunction

    function automatic logic [31:0] clamp32(longint v, ref logic err);
        if (v > 64'sd2147483647) begin
            err = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            err = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] clamp_sm(logic neg, logic [63:0] mag, ref logic err);
        logic [63:0] n;
        n = 64'd0 - mag;
        if (neg) begin
            if (mag > 64'h80000000) begin
                err = 1'b1;
                return 32'h80000000;
            end
            return n[31:0];
        end
        if (mag > 64'h7FFFFFFF) begin
            err = 1'b1;
            return 32'h7FFFFFFF;
        end
        return mag[31:0];
    endfunction

    // wrapped 64-bit sum to sign and magnitude
    function automatic void split_sm(logic [63:0] s, output logic neg,
                                     output logic [63:0] mag);
        if (s == 64'h8000000000000000) begin
            neg = 1'b0;
            mag = s;
        end else if (s[63]) begin
            neg = 1'b1;
            mag = 64'd0 - s;
        end else begin
            neg = 1'b0;
            mag = s;
        end
    endfunction

    function automatic logic [31:0] product_part(logic [63:0] s, ref logic err);
        logic neg;
        logic [63:0] mag;
        split_sm(s, neg, mag);
        return clamp_sm(neg, mag >> FB, err);
    endfunction

    function automatic logic [31:0] quotient_part(logic [63:0] s, logic [63:0] den,
                                                  ref logic err);
        logic neg;
        logic [63:0] mag, q, r;
        split_sm(s, neg, mag);
        q = mag / den;
        r = mag % den;
        if (q >= (64'd1 << (31 - FB)))
            return clamp_sm(neg, 64'h100000000, err);
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return clamp_sm(neg, q, err);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = angle_fix(HALF_PI_Q30);
            end else begin
                x = -y;
                y = t;
                z = -angle_fix(HALF_PI_Q30);
            end
        end
        for (int i = 0; i < NSTEP; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += angle_step(i);
            end else begin
                x -= dx;
                y += dy;
                z -= angle_step(i);
            end
        end
        return z;
    endfunction

    function automatic void rotate_polar(longint mag, longint ang, ref logic [31:0] re,
                                         ref logic [31:0] im, ref logic err);
        longint two_pi, pi_q, half, x, y, z, dx, dy;
        logic flip;
        two_pi = angle_fix(TWO_PI_Q30);
        pi_q = angle_fix(PI_Q30);
        half = angle_fix(HALF_PI_Q30);
        x = mag;
        y = 0;
        z = ang % two_pi;
        flip = 1'b0;
        if (z < 0) z += two_pi;
        if (z > pi_q) z -= two_pi;
        if (z > half) begin
            z -= pi_q;
            flip = 1'b1;
        end else if (z < -half) begin
            z += pi_q;
            flip = 1'b1;
        end
        for (int i = 0; i < NSTEP; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= angle_step(i);
            end else begin
                x += dx;
                y -= dy;
                z += angle_step(i);
            end
        end
        x = shr_floor(x * GAIN_Q30 + (longint'(1) << 29), 30);
        y = shr_floor(y * GAIN_Q30 + (longint'(1) << 29), 30);
        if (flip) begin
            x = -x;
            y = -y;
        end
        re = clamp32(x, err);
        im = clamp32(y, err);
    endfunction

    // expected result of one request
    function automatic rsp_t alu_result(req_t r);
        rsp_t o;
        logic err;
        logic [31:0] re, im;
        longint ar, ai, br, bi;
        logic [63:0] den;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        re = 0;
        im = 0;
        err = 1'b0;
        o = '0;
        case (r.mode)
            MODE_ADD: begin
                re = clamp32(ar + br, err);
                im = clamp32(ai + bi, err);
            end
            MODE_SUB: begin
                re = clamp32(ar - br, err);
                im = clamp32(ai - bi, err);
            end
            MODE_MUL: begin
                re = product_part(64'(ar * br) - 64'(ai * bi), err);
                im = product_part(64'(ar * bi) + 64'(ai * br), err);
            end
            MODE_DIV: begin
                den = 64'(br * br) + 64'(bi * bi);
                if (den == 0) begin
                    err = 1'b1;
                end else begin
                    re = quotient_part(64'(ar * br) + 64'(ai * bi), den, err);
                    im = quotient_part(64'(ai * br) - 64'(ar * bi), den, err);
                end
            end
            MODE_CNJ: begin
                re = clamp32(ar, err);
                im = clamp32(-ai, err);
            end
            MODE_NEG: begin
                re = clamp32(-ar, err);
                im = clamp32(-ai, err);
            end
            MODE_MAG: re = clamp_sm(1'b0, int_sqrt(64'(ar * ar) + 64'(ai * ai)), err);
            MODE_ARG: re = clamp32(vector_angle(ai, ar), err);
            MODE_POL: rotate_polar(ar, ai, re, im, err);
            MODE_EQU: o.equal_flag = (ar == br && ai == bi);
            default: ;
        endcase
        o.res_re = re;
        o.res_im = im;
        o.error_flag = err;
        return o;
    endfunction

    // predict on request transfer, compare on response transfer
    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            expected_rsp_q.delete();
            fail_count <= 0;
            reported = 0;
        end else begin
            if (req_valid && req_ready)
                expected_rsp_q.push_back(alu_result(req));
            if (rsp_valid && rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (reported < 10)
                        $display("ERROR: unexpected result %h", rsp);
                    reported++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (rsp !== want) begin
                        fail_count <= fail_count + 1;
                        if (reported < 10)
                            $display("ERROR: re %h/%h im %h/%h eq %b/%b err %b/%b (exp/act)",
                                     want.res_re, rsp.res_re, want.res_im, rsp.res_im,
                                     want.equal_flag, rsp.equal_flag,
                                     want.error_flag, rsp.error_flag);
                        reported++;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/complex_fixed_point_alu_top_tb.sv -----
module complex_fixed_point_alu_top_tb;
    import cxa_pkg::*;

    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   idle_cycles;
    logic timed_out;

    complex_fixed_point_alu_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    complex_fixed_point_alu_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
            timed_out   <= 1'b0;
        end
        else
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
            begin
                timed_out <= 1'b1;
                $display("FAIL complex_fixed_point_alu_top");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
            3: return 32'($signed($urandom_range(2 * 65536 * 256)) - 65536 * 256);
            4: return 0;
            default: return $urandom();
        endcase
    endfunction

    // one request, held until the transfer
    task automatic send_request(mode_t m, logic [31:0] ar, logic [31:0] ai,
                                logic [31:0] br, logic [31:0] bi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req.mode <= m;
        req.a_re <= ar;
        req.a_im <= ai;
        req.b_re <= br;
        req.b_im <= bi;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        mode_t m;
        logic [31:0] ar, ai, br, bi;
        m = mode_t'($urandom_range(15));
        if ($urandom_range(9) < 8) m = mode_t'($urandom_range(9));
        ar = pick_operand();
        ai = pick_operand();
        br = pick_operand();
        bi = pick_operand();
        if (m == MODE_EQU && $urandom_range(1))
        begin
            br = ar;
            bi = ai;
        end
        if (m == MODE_DIV && $urandom_range(9) == 0)
        begin
            br = 0;
            bi = 0;
        end
        send_request(m, ar, ai, br, bi);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes and special cases
        send_request(MODE_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF);
        send_request(MODE_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
        send_request(MODE_MUL, 32'h00030000, 32'h00020000, 32'hFFFF0000, 32'h00008000);
        send_request(MODE_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_request(MODE_DIV, 32'h00050000, 32'h00010000, 32'h00020000, 32'h00000000);
        send_request(MODE_DIV, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00000000);
        send_request(MODE_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'h00000000);
        send_request(MODE_CNJ, 32'h80000000, 32'h80000000, 0, 0);
        send_request(MODE_NEG, 32'h80000000, 32'h7FFFFFFF, 0, 0);
        send_request(MODE_MAG, 32'h80000000, 32'h80000000, 0, 0);
        send_request(MODE_MAG, 32'h00030000, 32'h00040000, 0, 0);
        send_request(MODE_ARG, 0, 0, 0, 0);
        send_request(MODE_ARG, 32'hFFFF0000, 32'h00000000, 0, 0);
        send_request(MODE_ARG, 32'hFFFF0000, 32'hFFFF0000, 0, 0);
        send_request(MODE_ARG, 32'h00000000, 32'h80000000, 0, 0);
        send_request(MODE_POL, 32'h00020000, 32'h7FFFFFFF, 0, 0);
        send_request(MODE_POL, 32'hFFFE0000, 32'h80000000, 0, 0);
        send_request(MODE_POL, 32'h7FFFFFFF, 32'h00030000, 0, 0);
        send_request(MODE_EQU, 32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF0);
        send_request(MODE_EQU, 32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF1);
        send_request(mode_t'(4'd10), 1, 2, 3, 4);
        send_request(mode_t'(4'd15), 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 200; n++) send_random();
        end
        req_valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending_count != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("PASS complex_fixed_point_alu_top");
        else
            $display("FAIL complex_fixed_point_alu_top");
        $finish;
    end
endmodule
